// ===== sv/mts_pkg.sv =====
// Shared types, codes and sizes for the min-tracking stack.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int DATA_W = 32;
    localparam int WORD_W = DATA_W + 2;
    localparam int APB_AW = 3;

    localparam logic signed [DATA_W-1:0] MIN_RESET = DATA_W'(9999);
    localparam logic [CAP_W-1:0]         CAP_RESET = CAP_W'(1024);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/mts_stack_ram.sv =====
// Stack entry memory: one write port, one read port, registered read data.
// Depends on mts_pkg for depth, widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module mts_stack_ram (
    input  wire logic                       clk,
    input  wire mts_pkg::ram_req_t          req,
    output logic [mts_pkg::WORD_W-1:0]      rd_data
);

    logic [mts_pkg::WORD_W-1:0] mem [mts_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mts_apb_regs.sv =====
// APB configuration register file holding the stack capacity.
// Depends on mts_pkg for the capacity width, reset value and address width.
`timescale 1ns / 1ps
`default_nettype none

module mts_apb_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mts_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [mts_pkg::CAP_W-1:0]        capacity
);

    logic [mts_pkg::CAP_W-1:0] capacity_reg;
    logic                      sel_cap;

    assign sel_cap  = (paddr[mts_pkg::APB_AW-1] == 1'b0);
    assign pready   = 1'b1;
    assign capacity = capacity_reg;
    assign prdata   = sel_cap ? {{(32 - mts_pkg::CAP_W){1'b0}}, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= mts_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_cap)
        begin
            capacity_reg <= pwdata[mts_pkg::CAP_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mts_core.sv =====
// Command sequencer and min-encoding datapath: read top, modify, write back.
// Depends on mts_pkg; drives mts_stack_ram through a request struct.
`timescale 1ns / 1ps
`default_nettype none

module mts_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         command,
    input  wire logic signed [mts_pkg::DATA_W-1:0]  value,
    input  wire logic [mts_pkg::CAP_W-1:0]          capacity,
    output mts_pkg::ram_req_t                       ram_req,
    input  wire logic [mts_pkg::WORD_W-1:0]         rd_data,
    output logic                                    done,
    output logic signed [mts_pkg::DATA_W-1:0]       popped_value,
    output logic signed [mts_pkg::DATA_W-1:0]       min_value,
    output logic                                    is_empty,
    output logic                                    is_full,
    output logic [1:0]                              status
);

    localparam int DW = mts_pkg::DATA_W;
    localparam int WW = mts_pkg::WORD_W;

    mts_pkg::state_t             state_reg, state_next;
    logic [mts_pkg::CNT_W-1:0]   count_reg, count_next;
    logic signed [DW-1:0]        min_reg, min_next;
    logic [1:0]                  cmd_reg;
    logic signed [DW-1:0]        val_reg;

    logic                        done_reg;
    logic signed [DW-1:0]        popped_reg, popped_next;
    logic                        empty_reg, full_reg, full_next;
    logic [1:0]                  status_reg, status_next;

    logic [mts_pkg::CMP_W-1:0]   eff_cap, cap_ext, depth_ext;
    logic                        full_now, accept;
    logic signed [WW-1:0]        val_w, min_w, top_w, enc_w, restore_w;

    assign accept    = start && (state_reg == mts_pkg::S_IDLE);
    assign busy      = (state_reg != mts_pkg::S_IDLE);

    assign cap_ext   = mts_pkg::CMP_W'(capacity);
    assign depth_ext = mts_pkg::CMP_W'(mts_pkg::DEPTH);
    assign eff_cap   = (cap_ext < depth_ext) ? cap_ext : depth_ext;
    assign full_now  = mts_pkg::CMP_W'(count_reg) >= eff_cap;
    assign full_next = mts_pkg::CMP_W'(count_next) >= eff_cap;

    assign val_w     = WW'(val_reg);
    assign min_w     = WW'(min_reg);
    assign top_w     = $signed(rd_data);
    assign enc_w     = (val_w <<< 1) - min_w;
    assign restore_w = (min_w <<< 1) - top_w;

    // fetch the top on accept; the sequencer holds off the next transfer meanwhile
    always_comb
    begin
        ram_req.re    = accept;
        ram_req.raddr = mts_pkg::ADDR_W'(count_reg - 1'b1);
        ram_req.we    = 1'b0;
        ram_req.waddr = mts_pkg::ADDR_W'(count_reg);
        ram_req.wdata = WW'(val_reg);
        count_next    = count_reg;
        min_next      = min_reg;
        popped_next   = '0;
        status_next   = mts_pkg::ST_DONE;
        state_next    = state_reg;

        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = mts_pkg::S_EXEC;
                end
            end
            mts_pkg::S_EXEC:
            begin
                state_next = mts_pkg::S_IDLE;
                case (cmd_reg)
                    mts_pkg::CMD_PUSH:
                    begin
                        if (full_now)
                        begin
                            status_next = mts_pkg::ST_PUSH_FULL;
                        end
                        else
                        begin
                            ram_req.we = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                min_next = val_reg;
                            end
                            else if (val_reg < min_reg)
                            begin
                                ram_req.wdata = enc_w;
                                min_next      = val_reg;
                            end
                        end
                    end
                    mts_pkg::CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mts_pkg::ST_POP_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            if (top_w >= min_w)
                            begin
                                popped_next = top_w[DW-1:0];
                            end
                            else
                            begin
                                popped_next = min_reg;
                                min_next    = restore_w[DW-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        status_next = mts_pkg::ST_DONE;
                    end
                endcase
            end
            default:
            begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::S_IDLE;
            count_reg <= '0;
            min_reg   <= mts_pkg::MIN_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            done_reg  <= (state_reg == mts_pkg::S_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            val_reg <= value;
        end
        if (state_reg == mts_pkg::S_EXEC)
        begin
            popped_reg <= popped_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= full_next;
            status_reg <= status_next;
        end
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign min_value    = min_reg;
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ===== sv/min_tracking_stack.sv =====
// An accepted command moves the sequencer to its execute state, and done is
// registered from that state. A new command is taken only once the sequencer
// is back in idle, as the stack memory's synchronous read fetches the top first.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset: entry count 0, minimum 9999, capacity 1024; memory contents are
// undefined and get no clearing pass, so commands are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         command,
    input  wire logic signed [mts_pkg::DATA_W-1:0]  value,
    output logic                                    done,
    output logic signed [mts_pkg::DATA_W-1:0]       popped_value,
    output logic signed [mts_pkg::DATA_W-1:0]       min_value,
    output logic                                    is_empty,
    output logic                                    is_full,
    output logic [1:0]                              status,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mts_pkg::APB_AW-1:0]         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic [mts_pkg::CAP_W-1:0]  capacity;
    mts_pkg::ram_req_t          ram_req;
    logic [mts_pkg::WORD_W-1:0] rd_data;

    mts_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    mts_stack_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    mts_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .value        (value),
        .capacity     (capacity),
        .ram_req      (ram_req),
        .rd_data      (rd_data),
        .done         (done),
        .popped_value (popped_value),
        .min_value    (min_value),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== sv/mts_checker.sv =====
// Port-level checker for min_tracking_stack, attached by bind.
// Depends on mts_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       is_empty,
    input wire logic       is_full,
    input wire logic [1:0] status
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result not strobed two cycles after transfer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == mts_pkg::ST_PUSH_FULL) |-> is_full)
        else $error("push rejected while not full");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == mts_pkg::ST_POP_EMPTY) |-> is_empty)
        else $error("pop rejected while not empty");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire
